// ----- hdl/turtle_plotter_grid_macros.svh -----
// turtle_plotter_grid_macros.svh: assertion macros for the turtle plotter checker
// no dependencies; included by the checker file
`ifndef TURTLE_PLOTTER_GRID_MACROS_SVH
`define TURTLE_PLOTTER_GRID_MACROS_SVH

// same-cycle implication
`define TPG_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TPG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/tpg_pkg.sv -----
// tpg_pkg: constants, command codes and shared types of the turtle plotter
// no dependencies; used by every module of the block but tpg_ram
`default_nettype none

package tpg_pkg;

   localparam int GRID_SIZE   = 64;
   localparam int ADDR_W      = $clog2(GRID_SIZE);
   localparam int ROW_W       = 64;
   localparam int IDX_W       = 6;
   localparam int DIST_W      = 8;
   localparam int KIND_W      = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [DIST_W-1:0] dist_type;
   typedef logic [ROW_W-1:0]  row_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [KIND_W-1:0] kind_type;

   localparam addr_type LAST = addr_type'(GRID_SIZE - 1);
   localparam row_type ROW_MASK =
      (GRID_SIZE >= ROW_W) ? {ROW_W{1'b1}} : ((row_type'(1) << GRID_SIZE) - row_type'(1));

   localparam kind_type KIND_PEN_UP     = 3'd0;
   localparam kind_type KIND_PEN_DOWN   = 3'd1;
   localparam kind_type KIND_TURN_RIGHT = 3'd2;
   localparam kind_type KIND_TURN_LEFT  = 3'd3;
   localparam kind_type KIND_MOVE       = 3'd4;
   localparam kind_type KIND_PRINT      = 3'd5;

   localparam logic [1:0] HEAD_PLUS_Y  = 2'd0;
   localparam logic [1:0] HEAD_PLUS_X  = 2'd1;
   localparam logic [1:0] HEAD_MINUS_Y = 2'd2;
   localparam logic [1:0] HEAD_MINUS_X = 2'd3;

   typedef enum logic [2:0] {
      CMD_PEN_UP,
      CMD_PEN_DOWN,
      CMD_TURN_RIGHT,
      CMD_TURN_LEFT,
      CMD_MOVE,
      CMD_PRINT
   } cmd_type;

   typedef struct packed {
      cmd_type  cmd;
      dist_type distance;
   } cmd_entry_type;

   typedef struct packed {
      logic          valid;
      cmd_entry_type entry;
   } q_item_type;

endpackage

`default_nettype wire

// ----- hdl/tpg_ram.sv -----
// tpg_ram: generic single write port, single read port ram with registered read
// no dependencies; holds the grid rows
`default_nettype none

module tpg_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/tpg_front.sv -----
// tpg_front: accepts command transactions and classifies them for the queue
// depends on tpg_pkg
`default_nettype none

module tpg_front (
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire tpg_pkg::kind_type req_kind,
   input  wire tpg_pkg::dist_type req_distance,
   output tpg_pkg::q_item_type    push,
   input  wire logic              push_stall
);

   logic             known;
   tpg_pkg::cmd_type cmd;

   always_comb begin
      known = 1'b1;
      cmd   = tpg_pkg::CMD_PEN_UP;
      case (req_kind)
         tpg_pkg::KIND_PEN_UP:     cmd = tpg_pkg::CMD_PEN_UP;
         tpg_pkg::KIND_PEN_DOWN:   cmd = tpg_pkg::CMD_PEN_DOWN;
         tpg_pkg::KIND_TURN_RIGHT: cmd = tpg_pkg::CMD_TURN_RIGHT;
         tpg_pkg::KIND_TURN_LEFT:  cmd = tpg_pkg::CMD_TURN_LEFT;
         tpg_pkg::KIND_MOVE:       cmd = tpg_pkg::CMD_MOVE;
         tpg_pkg::KIND_PRINT:      cmd = tpg_pkg::CMD_PRINT;
         default:                  known = 1'b0;
      endcase
   end

   // unknown kinds are taken and dropped
   assign push.valid          = req_valid && known;
   assign push.entry.cmd      = cmd;
   assign push.entry.distance = req_distance;
   assign req_stall           = push_stall;

endmodule

`default_nettype wire

// ----- hdl/tpg_queue.sv -----
// tpg_queue: short command queue between the front and the back
// depends on tpg_pkg
`default_nettype none

module tpg_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tpg_pkg::q_item_type push,
   output logic                     push_stall,
   output tpg_pkg::q_item_type      pop,
   input  wire logic                pop_stall
);

   tpg_pkg::cmd_entry_type      slot_ff [tpg_pkg::QUEUE_DEPTH];
   logic [tpg_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [tpg_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [tpg_pkg::QPTR_W:0]    count_ff, count_in;
   logic                        do_push, do_pop;

   function automatic logic [tpg_pkg::QPTR_W-1:0] next_ptr(
      input logic [tpg_pkg::QPTR_W-1:0] ptr
   );
      next_ptr = (ptr == tpg_pkg::QPTR_W'(tpg_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : ptr + tpg_pkg::QPTR_W'(1);
   endfunction

   assign push_stall = (count_ff == (tpg_pkg::QPTR_W + 1)'(tpg_pkg::QUEUE_DEPTH));
   assign pop.valid  = (count_ff != '0);
   assign pop.entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push.valid && !push_stall;
   assign do_pop     = pop.valid && !pop_stall;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (tpg_pkg::QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (tpg_pkg::QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/tpg_back.sv -----
// tpg_back: executes queued commands, owns turtle state, row valid bits and result register
// depends on tpg_pkg; drives the ports of the grid ram
`default_nettype none

module tpg_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tpg_pkg::q_item_type pop,
   output logic                     pop_stall,
   output logic                     ram_wr_en,
   output tpg_pkg::addr_type        ram_wr_addr,
   output tpg_pkg::row_type         ram_wr_data,
   output tpg_pkg::addr_type        ram_rd_addr,
   input  wire tpg_pkg::row_type    ram_rd_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output tpg_pkg::idx_type         rsp_row_index,
   output tpg_pkg::row_type         rsp_row_bits,
   output logic                     rsp_last_row
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROW_WR,
      ST_COL,
      ST_PRINT
   } state_type;

   state_type                      state_ff, state_in;
   tpg_pkg::addr_type              pos_x_ff, pos_x_in;
   tpg_pkg::addr_type              pos_y_ff, pos_y_in;
   logic [1:0]                     heading_ff, heading_in;
   logic                           pen_ff, pen_in;
   logic [tpg_pkg::GRID_SIZE-1:0]  valid_ff, valid_in;
   tpg_pkg::row_type               mask_ff, mask_in;
   tpg_pkg::addr_type              rd_row_ff, rd_row_in;
   tpg_pkg::addr_type              rd_left_ff, rd_left_in;
   logic                           wr_pend_ff, wr_pend_in;
   tpg_pkg::addr_type              wr_row_ff, wr_row_in;
   tpg_pkg::addr_type              fetch_row_ff, fetch_row_in;
   logic                           fetch_done_ff, fetch_done_in;
   logic                           pend_ff, pend_in;
   tpg_pkg::addr_type              pend_row_ff, pend_row_in;
   logic                           out_valid_ff, out_valid_in;
   tpg_pkg::addr_type              out_row_ff, out_row_in;
   tpg_pkg::row_type               out_bits_ff, out_bits_in;
   logic                           out_last_ff, out_last_in;

   tpg_pkg::addr_type              room, steps, lo, hi, new_x, new_y;
   tpg_pkg::row_type               row_span, col_bit;
   logic                           load;

   // move geometry from the current turtle state
   always_comb begin
      room  = '0;
      new_x = pos_x_ff;
      new_y = pos_y_ff;
      lo    = '0;
      hi    = '0;
      case (heading_ff)
         tpg_pkg::HEAD_PLUS_Y:  room = tpg_pkg::LAST - pos_y_ff;
         tpg_pkg::HEAD_PLUS_X:  room = tpg_pkg::LAST - pos_x_ff;
         tpg_pkg::HEAD_MINUS_Y: room = pos_y_ff;
         default:               room = pos_x_ff;
      endcase
      steps = (pop.entry.distance < tpg_pkg::dist_type'(room)) ?
              tpg_pkg::addr_type'(pop.entry.distance) : room;
      case (heading_ff)
         tpg_pkg::HEAD_PLUS_Y: begin
            new_y = pos_y_ff + steps;
            lo    = pos_y_ff + tpg_pkg::addr_type'(1);
            hi    = pos_y_ff + steps;
         end
         tpg_pkg::HEAD_PLUS_X: new_x = pos_x_ff + steps;
         tpg_pkg::HEAD_MINUS_Y: begin
            new_y = pos_y_ff - steps;
            lo    = pos_y_ff - steps;
            hi    = pos_y_ff - tpg_pkg::addr_type'(1);
         end
         default: new_x = pos_x_ff - steps;
      endcase
      row_span = (tpg_pkg::ROW_MASK << lo) & (tpg_pkg::ROW_MASK >> (tpg_pkg::LAST - hi));
      col_bit  = tpg_pkg::row_type'(1) << pos_y_ff;
   end

   always_comb begin
      state_in      = state_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      heading_in    = heading_ff;
      pen_in        = pen_ff;
      valid_in      = valid_ff;
      mask_in       = mask_ff;
      rd_row_in     = rd_row_ff;
      rd_left_in    = rd_left_ff;
      wr_pend_in    = wr_pend_ff;
      wr_row_in     = wr_row_ff;
      fetch_row_in  = fetch_row_ff;
      fetch_done_in = fetch_done_ff;
      pend_in       = pend_ff;
      pend_row_in   = pend_row_ff;
      out_valid_in  = out_valid_ff;
      out_row_in    = out_row_ff;
      out_bits_in   = out_bits_ff;
      out_last_in   = out_last_ff;
      pop_stall     = (state_ff != ST_IDLE);
      ram_wr_en     = 1'b0;
      ram_wr_addr   = pos_x_ff;
      ram_wr_data   = mask_ff;
      ram_rd_addr   = pos_x_ff;
      load          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (pop.valid) begin
               case (pop.entry.cmd)
                  tpg_pkg::CMD_PEN_UP:     pen_in = 1'b0;
                  tpg_pkg::CMD_PEN_DOWN:   pen_in = 1'b1;
                  tpg_pkg::CMD_TURN_RIGHT: heading_in = heading_ff + 2'd1;
                  tpg_pkg::CMD_TURN_LEFT:  heading_in = heading_ff - 2'd1;
                  tpg_pkg::CMD_MOVE: begin
                     pos_x_in = new_x;
                     pos_y_in = new_y;
                     if (pen_ff && (steps != '0)) begin
                        if (!heading_ff[0]) begin
                           mask_in  = row_span;
                           state_in = ST_ROW_WR;
                        end else begin
                           mask_in    = col_bit;
                           rd_row_in  = (heading_ff == tpg_pkg::HEAD_PLUS_X) ?
                                        pos_x_ff + tpg_pkg::addr_type'(1) :
                                        pos_x_ff - tpg_pkg::addr_type'(1);
                           rd_left_in = steps;
                           wr_pend_in = 1'b0;
                           state_in   = ST_COL;
                        end
                     end
                  end
                  tpg_pkg::CMD_PRINT: begin
                     fetch_row_in  = '0;
                     fetch_done_in = 1'b0;
                     pend_in       = 1'b0;
                     state_in      = ST_PRINT;
                  end
                  default: ;
               endcase
            end
         end

         ST_ROW_WR: begin
            ram_wr_en          = 1'b1;
            ram_wr_addr        = pos_x_ff;
            ram_wr_data        = (valid_ff[pos_x_ff] ? ram_rd_data : '0) | mask_ff;
            valid_in[pos_x_ff] = 1'b1;
            state_in           = ST_IDLE;
         end

         ST_COL: begin
            if (rd_left_ff != '0) begin
               ram_rd_addr = rd_row_ff;
               rd_row_in   = (heading_ff == tpg_pkg::HEAD_PLUS_X) ?
                             rd_row_ff + tpg_pkg::addr_type'(1) :
                             rd_row_ff - tpg_pkg::addr_type'(1);
               rd_left_in  = rd_left_ff - tpg_pkg::addr_type'(1);
               wr_pend_in  = 1'b1;
               wr_row_in   = rd_row_ff;
            end else begin
               wr_pend_in = 1'b0;
               state_in   = ST_IDLE;
            end
            if (wr_pend_ff) begin
               ram_wr_en           = 1'b1;
               ram_wr_addr         = wr_row_ff;
               ram_wr_data         = (valid_ff[wr_row_ff] ? ram_rd_data : '0) | mask_ff;
               valid_in[wr_row_ff] = 1'b1;
            end
         end

         ST_PRINT: begin
            load = pend_ff && (!out_valid_ff || !rsp_stall);
            if (pend_ff && !load) begin
               // hold the pending row by reading it again
               ram_rd_addr = pend_row_ff;
            end else if (!fetch_done_ff) begin
               ram_rd_addr   = fetch_row_ff;
               pend_in       = 1'b1;
               pend_row_in   = fetch_row_ff;
               fetch_row_in  = fetch_row_ff + tpg_pkg::addr_type'(1);
               fetch_done_in = (fetch_row_ff == tpg_pkg::LAST);
            end else begin
               pend_in = 1'b0;
            end
            if (load && (pend_row_ff == tpg_pkg::LAST)) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      if (load) begin
         out_valid_in = 1'b1;
         out_row_in   = pend_row_ff;
         out_bits_in  = (valid_ff[pend_row_ff] ? ram_rd_data : '0) & tpg_pkg::ROW_MASK;
         out_last_in  = (pend_row_ff == tpg_pkg::LAST);
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         heading_ff   <= tpg_pkg::HEAD_PLUS_Y;
         pen_ff       <= 1'b0;
         valid_ff     <= '0;
         wr_pend_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         heading_ff   <= heading_in;
         pen_ff       <= pen_in;
         valid_ff     <= valid_in;
         wr_pend_ff   <= wr_pend_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
      mask_ff       <= mask_in;
      rd_row_ff     <= rd_row_in;
      rd_left_ff    <= rd_left_in;
      wr_row_ff     <= wr_row_in;
      fetch_row_ff  <= fetch_row_in;
      fetch_done_ff <= fetch_done_in;
      pend_row_ff   <= pend_row_in;
      out_row_ff    <= out_row_in;
      out_bits_ff   <= out_bits_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_row_index = tpg_pkg::idx_type'(out_row_ff);
   assign rsp_row_bits  = out_bits_ff;
   assign rsp_last_row  = out_last_ff;

endmodule

`default_nettype wire

// ----- hdl/turtle_plotter_grid.sv -----
// turtle_plotter_grid: top level of the turtle plotter on a square bit grid
// depends on tpg_pkg, tpg_front, tpg_queue, tpg_back, tpg_ram
//
//   channel | ports                                   | moves
//   --------+-----------------------------------------+---------------------------
//   req     | req_valid req_stall req_kind            | one command per transaction
//           | req_distance                            |
//   rsp     | rsp_valid rsp_stall rsp_row_index       | one grid row per transaction
//           | rsp_row_bits rsp_last_row               |
//
// pen and turn commands complete in the idle state; a move with pen up or of zero cells too
// a drawn move along y is a read-modify-write of one row: read from the idle state, written in ST_ROW_WR
// a drawn move along x of n cells runs in ST_COL, one row per cycle on the ram port
// a print streams GRID_SIZE rows at one per cycle from the single read port while
// rsp_stall is low; rsp_stall holds the row in the output register and pauses reads
// reset clears the grid at once through per-row valid bits, with no clearing pass
`default_nettype none

module turtle_plotter_grid (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [2:0]            req_kind,
   input  wire logic [7:0]            req_distance,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [5:0]                 rsp_row_index,
   output logic [63:0]                rsp_row_bits,
   output logic                       rsp_last_row
);

   tpg_pkg::q_item_type push, pop;
   logic                push_stall, pop_stall;
   logic                ram_wr_en;
   tpg_pkg::addr_type   ram_wr_addr, ram_rd_addr;
   tpg_pkg::row_type    ram_wr_data, ram_rd_data;

   tpg_front u_front (
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_distance (req_distance),
      .push         (push),
      .push_stall   (push_stall)
   );

   tpg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_stall (push_stall),
      .pop        (pop),
      .pop_stall  (pop_stall)
   );

   tpg_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop           (pop),
      .pop_stall     (pop_stall),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_addr   (ram_rd_addr),
      .ram_rd_data   (ram_rd_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_row_index (rsp_row_index),
      .rsp_row_bits  (rsp_row_bits),
      .rsp_last_row  (rsp_last_row)
   );

   tpg_ram #(
      .WIDTH (tpg_pkg::ROW_W),
      .DEPTH (tpg_pkg::GRID_SIZE)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

// ----- hdl/tpg_checker.sv -----
// tpg_checker: assertions on the ports of turtle_plotter_grid, bound to the top level
// depends on tpg_pkg and turtle_plotter_grid_macros.svh
`default_nettype none
`include "turtle_plotter_grid_macros.svh"

module tpg_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [5:0]  rsp_row_index,
   input wire logic [63:0] rsp_row_bits,
   input wire logic        rsp_last_row
);

   localparam logic [5:0] LAST_IDX = 6'(tpg_pkg::GRID_SIZE - 1);

   `TPG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_row_index) && $stable(rsp_row_bits) && $stable(rsp_last_row), "stalled row changed")

   `TPG_ASSERT_NOW(a_last_is_final, clock, reset, rsp_valid && rsp_last_row, rsp_row_index == LAST_IDX, "last flag on a row other than the final one")

   `TPG_ASSERT_NOW(a_final_is_last, clock, reset, rsp_valid && !rsp_last_row, rsp_row_index != LAST_IDX, "final row without last flag")

   `TPG_ASSERT_NEXT(a_rows_in_order, clock, reset, rsp_valid && !rsp_stall && !rsp_last_row, !rsp_valid || (rsp_row_index == 6'($past(rsp_row_index) + 6'd1)), "rows of a print out of order")

   `TPG_ASSERT_NOW(a_mask, clock, reset, rsp_valid, (rsp_row_bits & ~tpg_pkg::ROW_MASK) == 64'd0, "cells beyond the grid set")

endmodule

bind turtle_plotter_grid tpg_checker u_tpg_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_row_index (rsp_row_index),
   .rsp_row_bits  (rsp_row_bits),
   .rsp_last_row  (rsp_last_row)
);

`default_nettype wire
